>>> hw/rtl/mesh_ring_next_hop_router_defines.svh
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef MESH_RING_NEXT_HOP_ROUTER_DEFINES_SVH
`define MESH_RING_NEXT_HOP_ROUTER_DEFINES_SVH

// same-cycle implication
`define MRNH_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define MRNH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/mrnh_pkg.sv
`default_nettype none
package mrnh_pkg;

	localparam int COORD_W   = 4;
	localparam int LAYER_W   = 2;
	localparam int CFG_W     = 5;
	localparam int RING_SIDE = 4;
	localparam int RING_BITS = $clog2(RING_SIDE);
	localparam int DATA_W    = 24;

	localparam logic [CFG_W-1:0] MESH_SIDE_RESET = CFG_W'(16);

	typedef logic [COORD_W-1:0] coord_t;

	localparam coord_t RING_POS_TABLE [RING_SIDE][RING_SIDE] = '{
		'{4'd0, 4'd15, 4'd10, 4'd9},
		'{4'd1, 4'd14, 4'd11, 4'd8},
		'{4'd2, 4'd13, 4'd12, 4'd7},
		'{4'd3, 4'd4,  4'd5,  4'd6}
	};

	typedef struct packed {
		coord_t              target_y;
		coord_t              target_x;
		logic [LAYER_W-1:0]  source_z;
		coord_t              source_y;
		coord_t              source_x;
	} req_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} hop_t;

	typedef struct packed {
		logic                same_ring;
		coord_t              source_cluster;
		coord_t              hop_ring_position;
		coord_t              hop_cluster;
		logic [LAYER_W-1:0]  hop_z;
		coord_t              hop_y;
		coord_t              hop_x;
	} resp_t;

	localparam int REQ_W  = $bits(req_t);
	localparam int RESP_W = $bits(resp_t);

endpackage
`default_nettype wire

>>> hw/rtl/mrnh_route.sv
`default_nettype none
module mrnh_route (
	input  mrnh_pkg::req_t req,
	output mrnh_pkg::hop_t hop
);
	import mrnh_pkg::*;

	localparam coord_t RING_MASK = COORD_W'(RING_SIDE - 1);

	coord_t low_x, high_x, low_y, high_y, step_x;

	assign low_x  = req.source_x & ~RING_MASK;
	assign high_x = low_x | RING_MASK;
	assign low_y  = req.source_y & ~RING_MASK;
	assign high_y = low_y | RING_MASK;

	// toward the target column, clamped to the cluster edge
	always_comb begin
		if (req.source_x > req.target_x) begin
			step_x = (low_x < req.target_x) ? req.target_x : low_x;
		end else begin
			step_x = (high_x > req.target_x) ? req.target_x : high_x;
		end
	end

	always_comb begin
		hop.x = req.source_x;
		hop.y = req.source_y;
		if (req.source_y > req.target_y) begin
			if (low_y <= req.target_y) begin
				hop.x = step_x;
				hop.y = req.target_y;
			end else begin
				hop.y = low_y;
			end
		end else if (req.source_y < req.target_y) begin
			if (high_y >= req.target_y) begin
				hop.x = step_x;
				hop.y = req.target_y;
			end else begin
				hop.y = high_y;
			end
		end else begin
			hop.x = step_x;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/mrnh_ring_addr.sv
`default_nettype none
module mrnh_ring_addr #(
	parameter int MAX_MESH_SIDE = 16
) (
	input  logic [mrnh_pkg::CFG_W-1:0] mesh_side,
	input  mrnh_pkg::req_t             req,
	input  mrnh_pkg::hop_t             hop,
	output mrnh_pkg::resp_t            resp
);
	import mrnh_pkg::*;

	localparam int SIDE_RAW = $clog2(MAX_MESH_SIDE + 1);
	localparam int SIDE_W   = (SIDE_RAW > CFG_W) ? SIDE_RAW : CFG_W;
	localparam int CPR_MAX  = MAX_MESH_SIDE / RING_SIDE;
	localparam int CPR_W    = $clog2(CPR_MAX + 1);
	localparam int CL_RAW   = $clog2((RING_SIDE - 1) * CPR_MAX + RING_SIDE);
	localparam int CL_W     = (CL_RAW > COORD_W) ? CL_RAW : COORD_W;

	logic [SIDE_W-1:0] side_ext, side_sat;
	logic [CPR_W-1:0]  per_row;
	logic [CL_W-1:0]   src_cl, hop_cl;

	assign side_ext = SIDE_W'(mesh_side);
	assign side_sat = (side_ext > SIDE_W'(MAX_MESH_SIDE)) ? SIDE_W'(MAX_MESH_SIDE) : side_ext;
	assign per_row  = CPR_W'(side_sat >> RING_BITS);

	assign src_cl = CL_W'(req.source_y[COORD_W-1:RING_BITS]) * CL_W'(per_row)
		+ CL_W'(req.source_x[COORD_W-1:RING_BITS]);
	assign hop_cl = CL_W'(hop.y[COORD_W-1:RING_BITS]) * CL_W'(per_row)
		+ CL_W'(hop.x[COORD_W-1:RING_BITS]);

	assign resp.hop_x             = hop.x;
	assign resp.hop_y             = hop.y;
	assign resp.hop_z             = req.source_z;
	assign resp.hop_cluster       = hop_cl[COORD_W-1:0];
	assign resp.hop_ring_position =
		RING_POS_TABLE[hop.x[RING_BITS-1:0]][hop.y[RING_BITS-1:0]];
	assign resp.source_cluster    = src_cl[COORD_W-1:0];
	assign resp.same_ring         = (src_cl == hop_cl);

endmodule
`default_nettype wire

>>> hw/rtl/mesh_ring_next_hop_router.sv
// channel | direction | handshake          | payload
// s       | in        | s_tvalid/s_tready  | s_tdata: source and target coordinates
// m       | out       | m_tvalid/m_tready  | m_tdata: next hop and ring address
// cfg     | in        | cfg_valid/cfg_ready| cfg_data: mesh_side
//
// one item per cycle sustained while m_tready is high; a transaction passes the
// input register, then the result register after the route and table logic
// arst_n clears both stage valids and sets mesh_side to 16
// a stalled result holds the result register; the input register still takes
// an item when empty, or while the result register is free or drains in that cycle
`default_nettype none
`include "mesh_ring_next_hop_router_defines.svh"
module mesh_ring_next_hop_router #(
	parameter int MAX_MESH_SIDE = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// source_x, source_y, source_z, target_x, target_y, zero fill
	input  logic [mrnh_pkg::DATA_W-1:0]  s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// hop_x, hop_y, hop_z, hop_cluster, hop_ring_position, source_cluster,
	// same_ring, zero fill
	output logic [mrnh_pkg::DATA_W-1:0]  m_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mrnh_pkg::CFG_W-1:0]   cfg_data
);
	import mrnh_pkg::*;

	logic [CFG_W-1:0] mesh_side_q;
	logic             valid_s1, valid_s2;
	logic             adv_s1;
	req_t             req_s1;
	resp_t            resp_s2;
	hop_t             hop;
	resp_t            resp;

	assign cfg_ready = 1'b1;
	assign adv_s1    = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_side_q <= MESH_SIDE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mesh_side_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1 <= req_t'(s_tdata[REQ_W-1:0]);
		end
		if (valid_s1 && adv_s1) begin
			resp_s2 <= resp;
		end
	end

	mrnh_route u_route (
		.req (req_s1),
		.hop (hop)
	);

	mrnh_ring_addr #(
		.MAX_MESH_SIDE (MAX_MESH_SIDE)
	) u_ring_addr (
		.mesh_side (mesh_side_q),
		.req       (req_s1),
		.hop       (hop),
		.resp      (resp)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(DATA_W - RESP_W){1'b0}}, resp_s2};

	`MRNH_ASSERT_NEXT(a_accept_fills_s1, s_tvalid && s_tready, valid_s1)
	`MRNH_ASSERT_SAME(a_ready_when_out_free, !m_tvalid, s_tready)
	`MRNH_ASSERT_NEXT(a_layer_passes, valid_s1 && adv_s1,
		m_tvalid && resp_s2.hop_z == $past(req_s1.source_z))
	`MRNH_ASSERT_SAME(a_ring_needs_cluster,
		m_tvalid && resp_s2.hop_cluster != resp_s2.source_cluster, !resp_s2.same_ring)

endmodule
`default_nettype wire

>>> test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mrnh_pkg::*;

	localparam int MAX_SIDE     = 16;
	localparam int SETTLE_TICKS = 6;
	localparam int TICK_LIMIT   = 200000;
	localparam int PHASE_ITEMS  = 125;

	typedef enum logic [1:0] {
		JOB_ROUTE,
		JOB_MESH_SIDE,
		JOB_QUIESCE
	} job_e;

	typedef struct {
		job_e                kind;
		req_t                req;
		logic [CFG_W-1:0]    side;
	} job_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [DATA_W-1:0]   s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [DATA_W-1:0]   m_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data = '0;

	job_t                pending[$];
	resp_t               route_book[$];
	logic [CFG_W-1:0]    side_now = MESH_SIDE_RESET;
	int unsigned         tick_count = 0;
	int unsigned         quiet_ticks = 0;
	int unsigned         route_accepted = 0;
	int unsigned         route_returned = 0;
	int unsigned         results_seen = 0;
	int unsigned         cluster_changes = 0;
	int unsigned         side_writes = 0;
	int unsigned         mismatches = 0;

	mesh_ring_next_hop_router i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// x step toward the target, clamped to the edge of the source cluster
	function automatic int clamp_x(int sx, int dx);
		int lo, hi;
		lo = sx - (sx % RING_SIDE);
		hi = lo + RING_SIDE - 1;
		if (sx > dx)
			return (lo < dx) ? dx : lo;
		return (hi > dx) ? dx : hi;
	endfunction

	function automatic resp_t route_hop(req_t r, logic [CFG_W-1:0] side);
		int sx, sy, dx, dy, nx, ny, low_y, per_row, src_cl, hop_cl;
		resp_t p;
		sx = r.source_x;
		sy = r.source_y;
		dx = r.target_x;
		dy = r.target_y;
		nx = sx;
		ny = sy;
		low_y = sy - (sy % RING_SIDE);
		if (sy > dy) begin
			ny = low_y;
			if (low_y <= dy) begin
				nx = clamp_x(sx, dx);
				ny = dy;
			end
		end else if (sy < dy) begin
			ny = low_y + RING_SIDE - 1;
			if (ny >= dy) begin
				nx = clamp_x(sx, dx);
				ny = dy;
			end
		end else begin
			nx = clamp_x(sx, dx);
		end
		per_row = ((int'(side) > MAX_SIDE) ? MAX_SIDE : int'(side)) / RING_SIDE;
		src_cl = (sy / RING_SIDE) * per_row + sx / RING_SIDE;
		hop_cl = (ny / RING_SIDE) * per_row + nx / RING_SIDE;
		p.hop_x = coord_t'(nx);
		p.hop_y = coord_t'(ny);
		p.hop_z = r.source_z;
		p.hop_cluster = coord_t'(hop_cl);
		p.hop_ring_position = RING_POS_TABLE[nx % RING_SIDE][ny % RING_SIDE];
		p.source_cluster = coord_t'(src_cl);
		p.same_ring = (src_cl == hop_cl);
		return p;
	endfunction

	function automatic void queue_route(int sx, int sy, int sz, int tx, int ty);
		job_t j;
		j.kind = JOB_ROUTE;
		j.side = '0;
		j.req.source_x = coord_t'(sx);
		j.req.source_y = coord_t'(sy);
		j.req.source_z = LAYER_W'(sz);
		j.req.target_x = coord_t'(tx);
		j.req.target_y = coord_t'(ty);
		pending.insert(pending.size(), j);
	endfunction

	function automatic void queue_job(job_e kind, int side);
		job_t j;
		j.kind = kind;
		j.req = '0;
		j.side = CFG_W'(side);
		pending.insert(pending.size(), j);
	endfunction

	// mostly routes inside the mesh, many toward nearby nodes, some raw noise
	function automatic void queue_random_route(int side);
		int span, mode, sx, sy, tx, ty;
		span = (side >= RING_SIDE && side <= MAX_SIDE) ? side : MAX_SIDE;
		mode = $urandom_range(99);
		if (mode < 30) begin
			sx = $urandom_range(15);
			sy = $urandom_range(15);
			tx = $urandom_range(15);
			ty = $urandom_range(15);
		end else begin
			sx = $urandom_range(span - 1);
			sy = $urandom_range(span - 1);
			if (mode < 65) begin
				tx = $urandom_range(span - 1);
				ty = $urandom_range(span - 1);
			end else begin
				tx = (sx & ~3) + $urandom_range(3);
				ty = (mode < 80) ? sy : (sy & ~3) + $urandom_range(3);
			end
		end
		queue_route(sx, sy, $urandom_range(3), tx, ty);
	endfunction

	function automatic bit stall_roll();
		bit calm;
		calm = (tick_count % 5000) >= 1000 && (tick_count % 5000) < 2500;
		return !calm && $urandom_range(99) < 20;
	endfunction

	// driver
	always @(posedge clk) begin
		logic              send_valid, set_valid, settled;
		logic [DATA_W-1:0] send_data;
		logic [CFG_W-1:0]  set_data;
		send_valid = s_tvalid;
		send_data = s_tdata;
		set_valid = cfg_valid;
		set_data = cfg_data;
		settled = quiet_ticks >= SETTLE_TICKS;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				send_valid = 1'b0;
			if (cfg_valid && cfg_ready)
				set_valid = 1'b0;
			if (!send_valid && !set_valid && pending.size() != 0) begin
				case (pending[0].kind)
				JOB_ROUTE: begin
					if (!stall_roll()) begin
						send_valid = 1'b1;
						send_data = DATA_W'(pending[0].req);
						void'(pending.pop_front());
					end
				end
				JOB_MESH_SIDE: begin
					if (settled) begin
						set_valid = 1'b1;
						set_data = pending[0].side;
						void'(pending.pop_front());
					end
				end
				JOB_QUIESCE: begin
					if (settled)
						void'(pending.pop_front());
				end
				default: begin
					void'(pending.pop_front());
				end
				endcase
			end
			if (s_tvalid || cfg_valid || route_accepted != route_returned)
				quiet_ticks <= 0;
			else
				quiet_ticks <= quiet_ticks + 1;
		end
		s_tvalid <= send_valid;
		s_tdata <= send_data;
		cfg_valid <= set_valid;
		cfg_data <= set_data;
	end

	// monitor
	always @(posedge clk) begin
		resp_t got, want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				side_now = cfg_data;
				side_writes++;
			end
			if (s_tvalid && s_tready) begin
				route_book.insert(route_book.size(),
					route_hop(req_t'(s_tdata[REQ_W-1:0]), side_now));
				route_accepted <= route_accepted + 1;
			end
			if (m_tvalid && m_tready) begin
				got = resp_t'(m_tdata[RESP_W-1:0]);
				results_seen++;
				if (route_book.size() == 0) begin
					$error("result transaction with nothing expected: %h", m_tdata);
					mismatches++;
				end else begin
					want = route_book.pop_front();
					route_returned <= route_returned + 1;
					if (!want.same_ring)
						cluster_changes++;
					if (got.hop_x !== want.hop_x) begin
						$error("hop_x: expected %0d, got %0d", want.hop_x, got.hop_x);
						mismatches++;
					end
					if (got.hop_y !== want.hop_y) begin
						$error("hop_y: expected %0d, got %0d", want.hop_y, got.hop_y);
						mismatches++;
					end
					if (got.hop_z !== want.hop_z) begin
						$error("hop_z: expected %0d, got %0d", want.hop_z, got.hop_z);
						mismatches++;
					end
					if (got.hop_cluster !== want.hop_cluster) begin
						$error("hop_cluster: expected %0d, got %0d",
							want.hop_cluster, got.hop_cluster);
						mismatches++;
					end
					if (got.hop_ring_position !== want.hop_ring_position) begin
						$error("hop_ring_position: expected %0d, got %0d",
							want.hop_ring_position, got.hop_ring_position);
						mismatches++;
					end
					if (got.source_cluster !== want.source_cluster) begin
						$error("source_cluster: expected %0d, got %0d",
							want.source_cluster, got.source_cluster);
						mismatches++;
					end
					if (got.same_ring !== want.same_ring) begin
						$error("same_ring: expected %0d, got %0d",
							want.same_ring, got.same_ring);
						mismatches++;
					end
				end
			end
		end
		m_tready <= !stall_roll();
	end

	always @(posedge clk) begin
		tick_count <= tick_count + 1;
		if (tick_count >= TICK_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int phase_sides[] = '{16, 8, 4, 12, 31, 0, 16, 3, 20, 12, 8, 4, 17, 16};

		// directed, reset mesh side
		queue_route(5, 6, 1, 5, 6);
		queue_route(0, 0, 0, 0, 0);
		queue_route(15, 15, 3, 15, 15);
		queue_route(0, 0, 0, 15, 15);
		queue_route(15, 15, 3, 0, 0);
		queue_route(15, 0, 2, 0, 15);
		queue_route(0, 15, 1, 15, 0);
		queue_route(1, 7, 0, 14, 5);
		queue_route(9, 9, 2, 2, 1);
		queue_route(13, 12, 3, 2, 14);
		queue_route(4, 3, 0, 15, 3);
		queue_route(11, 3, 1, 0, 3);
		queue_route(10, 3, 2, 9, 3);
		queue_route(6, 4, 3, 6, 0);
		queue_job(JOB_MESH_SIDE, 4);
		queue_route(14, 13, 1, 2, 2);
		queue_route(3, 3, 0, 3, 3);
		// zero and sub-ring sides give no clusters per row
		queue_job(JOB_MESH_SIDE, 0);
		queue_route(9, 9, 2, 1, 9);
		queue_route(12, 3, 3, 12, 3);
		queue_job(JOB_MESH_SIDE, 3);
		queue_route(7, 12, 0, 7, 15);
		// saturates to the largest mesh
		queue_job(JOB_MESH_SIDE, 31);
		queue_route(2, 14, 1, 13, 1);
		queue_route(0, 0, 0, 15, 15);
		// coordinates beyond the mesh edge
		queue_job(JOB_MESH_SIDE, 12);
		queue_route(15, 14, 3, 0, 0);
		queue_route(11, 11, 2, 11, 4);

		foreach (phase_sides[p]) begin
			queue_job(JOB_MESH_SIDE, phase_sides[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					queue_job(JOB_QUIESCE, 0);
				queue_random_route(phase_sides[p]);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (pending.size() != 0 || s_tvalid || cfg_valid);
		while (route_book.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (route_book.size() != 0) begin
			$error("%0d routes never came back", route_book.size());
			mismatches++;
		end
		$display("%0d mesh side writes, from zero and sub-ring sizes through saturated ones",
			side_writes);
		$display("%0d next hops checked, %0d of them leaving the source cluster",
			results_seen, cluster_changes);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> mesh_ring_next_hop_router.f
+incdir+hw/rtl
hw/rtl/mrnh_pkg.sv
hw/rtl/mrnh_route.sv
hw/rtl/mrnh_ring_addr.sv
hw/rtl/mesh_ring_next_hop_router.sv
test/testbench.sv
